/* rtl/dag_ancestor_closure_macros.svh */
// Assertion macros for the ancestor-closure block.
// Expects clk and rst_n in scope at the point of use.
`ifndef DAG_ANCESTOR_CLOSURE_MACROS_SVH
`define DAG_ANCESTOR_CLOSURE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DAC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DAC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/dac_pkg.sv */
// Shared types and constants for the ancestor-closure block.
// No dependencies; used by the sequencer, datapath and top level.
package dac_pkg;

  localparam int MASK_W = 64;  // ancestor mask / row width
  localparam int NODE_W = 6;   // node index field width
  localparam int CNT_W  = 7;   // node_count register width

  // Input opcodes
  localparam logic OP_EDGE   = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [NODE_W-1:0] from_node;
    logic [NODE_W-1:0] to_node;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] node_index;
    logic [MASK_W-1:0] ancestor_mask;
    logic              last;
  } out_item_t;

  // Microprogram step addresses
  typedef logic [3:0] step_t;
  localparam step_t ST_WAIT     = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_EDGE_WR  = 4'd2;
  localparam step_t ST_FIN_INIT = 4'd3;
  localparam step_t ST_K_RD     = 4'd4;
  localparam step_t ST_K_LATCH  = 4'd5;
  localparam step_t ST_V_RD     = 4'd6;
  localparam step_t ST_V_WR     = 4'd7;
  localparam step_t ST_K_NEXT   = 4'd8;
  localparam step_t ST_E_RD     = 4'd9;
  localparam step_t ST_E_OUT    = 4'd10;
  localparam step_t ST_CLEAR    = 4'd11;

  typedef enum logic [1:0] {HOLD_NONE, HOLD_IN, HOLD_OUT} hold_t;
  typedef enum logic [1:0] {RD_NONE, RD_TO, RD_K, RD_V} rd_sel_t;
  typedef enum logic [1:0] {WR_NONE, WR_EDGE, WR_CLOSE} wr_sel_t;
  typedef enum logic [2:0] {J_NEXT, J_ALWAYS, J_FIN, J_V_MORE, J_K_MORE} jcond_t;

  // One microcode word
  typedef struct packed {
    hold_t   hold;
    logic    in_ready;
    logic    capture;
    rd_sel_t rd_sel;
    logic    latch_rowk;
    wr_sel_t wr_sel;
    logic    k_clr;
    logic    k_inc;
    logic    v_clr;
    logic    v_inc;
    logic    out_load;
    logic    clear_all;
    jcond_t  jcond;
    step_t   target;
  } ctrl_word_t;

  // Datapath status seen by the sequencer
  typedef struct packed {
    logic in_valid;
    logic is_fin;
    logic v_more;
    logic k_more;
    logic out_busy;
  } dp_status_t;

endpackage

/* rtl/dac_seq.sv */
// Microcode sequencer: step counter, control ROM and jump logic.
// Depends on dac_pkg.
module dac_seq
  import dac_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  dp_status_t status,
  output ctrl_word_t ctrl
);

  // Control ROM
  function automatic ctrl_word_t ucode(input step_t s);
    ctrl_word_t w;
    w = '0;
    unique case (s)
      ST_WAIT: begin
        w.hold     = HOLD_IN;
        w.in_ready = 1'b1;
        w.capture  = 1'b1;
      end
      ST_DISPATCH: begin
        w.rd_sel = RD_TO;
        w.jcond  = J_FIN;
        w.target = ST_FIN_INIT;
      end
      ST_EDGE_WR: begin
        w.wr_sel = WR_EDGE;
        w.jcond  = J_ALWAYS;
        w.target = ST_WAIT;
      end
      ST_FIN_INIT: begin
        w.k_clr = 1'b1;
        w.v_clr = 1'b1;
      end
      ST_K_RD:    w.rd_sel = RD_K;
      ST_K_LATCH: w.latch_rowk = 1'b1;
      ST_V_RD:    w.rd_sel = RD_V;
      ST_V_WR: begin
        w.wr_sel = WR_CLOSE;
        w.v_inc  = 1'b1;
        w.jcond  = J_V_MORE;
        w.target = ST_V_RD;
      end
      ST_K_NEXT: begin
        w.v_clr  = 1'b1;
        w.k_inc  = 1'b1;
        w.jcond  = J_K_MORE;
        w.target = ST_K_RD;
      end
      ST_E_RD: w.rd_sel = RD_V;
      ST_E_OUT: begin
        w.hold     = HOLD_OUT;
        w.out_load = 1'b1;
        w.v_inc    = 1'b1;
        w.jcond    = J_V_MORE;
        w.target   = ST_E_RD;
      end
      ST_CLEAR: begin
        w.clear_all = 1'b1;
        w.jcond     = J_ALWAYS;
        w.target    = ST_WAIT;
      end
      default: begin
        w.jcond  = J_ALWAYS;
        w.target = ST_WAIT;
      end
    endcase
    return w;
  endfunction

  step_t      step_r, step_nxt;
  ctrl_word_t word;
  logic       held;
  logic       take;

  assign word = ucode(step_r);

  // Step repeats with no side effects while its wait condition holds
  always_comb begin
    unique case (word.hold)
      HOLD_IN:  held = !status.in_valid;
      HOLD_OUT: held = status.out_busy;
      default:  held = 1'b0;
    endcase
  end

  // Jump condition
  always_comb begin
    unique case (word.jcond)
      J_ALWAYS: take = 1'b1;
      J_FIN:    take = status.is_fin;
      J_V_MORE: take = status.v_more;
      J_K_MORE: take = status.k_more;
      default:  take = 1'b0;
    endcase
  end

  always_comb begin
    priority if (held) begin
      step_nxt = step_r;
    end else if (take) begin
      step_nxt = word.target;
    end else begin
      step_nxt = step_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_WAIT;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Gate the effects of a held step
  always_comb begin
    ctrl = word;
    if (held) begin
      ctrl.capture    = 1'b0;
      ctrl.rd_sel     = RD_NONE;
      ctrl.latch_rowk = 1'b0;
      ctrl.wr_sel     = WR_NONE;
      ctrl.k_clr      = 1'b0;
      ctrl.k_inc      = 1'b0;
      ctrl.v_clr      = 1'b0;
      ctrl.v_inc      = 1'b0;
      ctrl.out_load   = 1'b0;
      ctrl.clear_all  = 1'b0;
    end
  end

endmodule

/* rtl/dac_dpath.sv */
// Datapath: row memory with valid bits, k/v counters, row-k latch,
// input capture, node_count register and output register. Uses dac_pkg.
module dac_dpath
  import dac_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  ctrl_word_t       ctrl,
  output dp_status_t       status,
  input  logic             in_valid,
  input  in_item_t         in_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data
);

  localparam int IDX_W = $clog2(MAX_NODES);
  localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_NODES);

  in_item_t          item_r;
  logic [CNT_W-1:0]  node_count_r;
  logic [IDX_W-1:0]  last_idx;
  logic [MASK_W-1:0] keep;
  logic [IDX_W-1:0]  k_r, v_r;
  logic [IDX_W-1:0]  to_idx;
  logic [MASK_W-1:0] mem_r [MAX_NODES];
  logic [MAX_NODES-1:0] valid_r;
  logic [MASK_W-1:0] rd_q_r;
  logic              rd_vld_r;
  logic [MASK_W-1:0] rd_raw;
  logic [MASK_W-1:0] rd_data;
  logic [MASK_W-1:0] rowk_r;
  logic [IDX_W-1:0]  rd_addr;
  logic              rd_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [MASK_W-1:0] wr_data;
  logic              wr_en;
  logic              edge_ok;
  logic [MASK_W-1:0] from_bit;
  out_item_t         out_r;
  logic              out_valid_r;

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= CNT_W'(64);
    end else if (cfg_we) begin
      node_count_r <= cfg_wdata;
    end
  end

  // Last node in use: node_count held to 1..MAX_NODES, minus one
  always_comb begin
    priority if (node_count_r == '0) begin
      last_idx = '0;
    end else if (node_count_r > MAX_N) begin
      last_idx = IDX_W'(MAX_NODES - 1);
    end else begin
      last_idx = IDX_W'(node_count_r - CNT_W'(1));
    end
  end

  always_comb begin
    for (int i = 0; i < MASK_W; i++) begin
      keep[i] = (CNT_W'(i) <= CNT_W'(last_idx));
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      item_r <= in_data;
    end
  end

  assign to_idx  = IDX_W'(item_r.to_node);
  assign edge_ok = (CNT_W'(item_r.from_node) <= CNT_W'(last_idx)) &&
                   (CNT_W'(item_r.to_node) <= CNT_W'(last_idx));
  assign from_bit = {{(MASK_W-1){1'b0}}, 1'b1} << item_r.from_node;

  // Loop counters
  always_ff @(posedge clk) begin
    if (ctrl.k_clr) begin
      k_r <= '0;
    end else if (ctrl.k_inc) begin
      k_r <= IDX_W'(k_r + 1'b1);
    end
    if (ctrl.v_clr) begin
      v_r <= '0;
    end else if (ctrl.v_inc) begin
      v_r <= IDX_W'(v_r + 1'b1);
    end
  end

  // Read address select
  always_comb begin
    rd_en = 1'b1;
    unique case (ctrl.rd_sel)
      RD_TO:   rd_addr = to_idx;
      RD_K:    rd_addr = k_r;
      RD_V:    rd_addr = v_r;
      default: begin
        rd_addr = v_r;
        rd_en   = 1'b0;
      end
    endcase
  end

  // Row memory, registered read; a row never written since clear reads as zero
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q_r   <= mem_r[rd_addr];
      rd_vld_r <= valid_r[rd_addr];
    end
  end

  // Edge loads keep the full row; closure and emit reads are cut to the nodes in use
  assign rd_raw  = rd_vld_r ? rd_q_r : '0;
  assign rd_data = rd_raw & keep;

  // Row-k latch for one pass of the closure
  always_ff @(posedge clk) begin
    if (ctrl.latch_rowk) begin
      rowk_r <= rd_data;
    end
  end

  // Write port: edge set, or OR of row k into row v when v has k as ancestor
  always_comb begin
    unique case (ctrl.wr_sel)
      WR_EDGE: begin
        wr_en   = edge_ok;
        wr_addr = to_idx;
        wr_data = rd_raw | from_bit;
      end
      WR_CLOSE: begin
        wr_en   = rd_data[NODE_W'(k_r)];
        wr_addr = v_r;
        wr_data = rd_data | rowk_r;
      end
      default: begin
        wr_en   = 1'b0;
        wr_addr = v_r;
        wr_data = rd_data;
      end
    endcase
  end

  // Row valid bits
  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear_all) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctrl.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.out_load) begin
      out_r.node_index    <= NODE_W'(v_r);
      out_r.ancestor_mask <= rd_data;
      out_r.last          <= (v_r == last_idx);
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Status to sequencer
  assign status.in_valid = in_valid;
  assign status.is_fin   = (item_r.opcode == OP_FINISH);
  assign status.v_more   = (v_r != last_idx);
  assign status.k_more   = (k_r != last_idx);
  assign status.out_busy = out_valid_r && !out_ready;

endmodule

/* rtl/dag_ancestor_closure.sv */
// Top level of the ancestor-closure block: sequencer plus datapath.
// Depends on dac_pkg, dac_seq, dac_dpath and the assertion macro header.
//
//   Channel  Direction  Handshake              Payload
//   in_      input      in_valid / in_ready    in_data   (in_item_t)
//   out_     output     out_valid / out_ready  out_data  (out_item_t)
//   cfg_     input      cfg_we                 cfg_wdata (node_count)
//
// An edge steps through wait, read row and write row on the one memory port.
// A finish with n nodes runs one Warshall pass per node k: each pass reads
// row k, then reads and writes every row v in turn.
// Reset is synchronous; row valid bits clear at once, so no clearing pass.
// A stalled out_ready holds emission at the current node; the last result
// may wait in the output register while the next item is taken.
`include "dag_ancestor_closure_macros.svh"

module dag_ancestor_closure
  import dac_pkg::*;
#(
  parameter int MAX_NODES = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_item_t         in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CNT_W-1:0] cfg_wdata
);

  ctrl_word_t ctrl;
  dp_status_t status;

  dac_seq u_seq (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .ctrl   (ctrl)
  );

  dac_dpath #(
    .MAX_NODES (MAX_NODES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctrl      (ctrl),
    .status    (status),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  assign in_ready = ctrl.in_ready;

  // Checks
  `DAC_ASSERT_NEXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken mid-work")
  `DAC_ASSERT_SAME(a_no_overrun, ctrl.out_load, !(out_valid && !out_ready), "result overwritten")
  `DAC_ASSERT_SAME(a_wr_not_idle, ctrl.wr_sel != WR_NONE, !in_ready, "row write while idle")
  `DAC_ASSERT_NEXT(a_clear_idle, ctrl.clear_all, in_ready, "no return to wait after clear")

endmodule
